// ===== sv/sbct_pkg.sv =====
// shared constants and types for the segment versus box cull test
package sbct_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ACC_W           = 64;
  localparam int NUM_REGS        = 4;

  typedef enum logic [1:0] {
    REG_SWEEP_X,
    REG_SWEEP_Y,
    REG_SWEEP_Z,
    REG_AXIAL_ONLY
  } reg_idx_t;

endpackage

// ===== sv/sbct_in_if.sv =====
// input channel: one segment and one box per transaction
interface sbct_in_if #(
  parameter int CW = sbct_pkg::COORD_WIDTH_DEF
);
  logic              valid;
  logic              ready;
  logic signed [CW-1:0] seg_mid_x;
  logic signed [CW-1:0] seg_mid_y;
  logic signed [CW-1:0] seg_mid_z;
  logic signed [CW-1:0] seg_half_x;
  logic signed [CW-1:0] seg_half_y;
  logic signed [CW-1:0] seg_half_z;
  logic signed [CW-1:0] box_center_x;
  logic signed [CW-1:0] box_center_y;
  logic signed [CW-1:0] box_center_z;
  logic [CW-2:0]        box_half_x;
  logic [CW-2:0]        box_half_y;
  logic [CW-2:0]        box_half_z;

  modport source (
    output valid, seg_mid_x, seg_mid_y, seg_mid_z, seg_half_x, seg_half_y, seg_half_z,
           box_center_x, box_center_y, box_center_z, box_half_x, box_half_y, box_half_z,
    input  ready
  );
  modport sink (
    input  valid, seg_mid_x, seg_mid_y, seg_mid_z, seg_half_x, seg_half_y, seg_half_z,
           box_center_x, box_center_y, box_center_z, box_half_x, box_half_y, box_half_z,
    output ready
  );
endinterface

// ===== sv/sbct_out_if.sv =====
// result channel: cull flag per transaction
interface sbct_out_if;
  logic valid;
  logic ready;
  logic culled;

  modport source (output valid, culled, input ready);
  modport sink   (input valid, culled, output ready);
endinterface

// ===== sv/segment_box_cull_test.sv =====
// Segment versus axis-aligned box cull test, five-stage pipeline with APB
// configuration. Coordinates are signed fixed point (Q23.8 at the default
// width); sweep sizes and box half extents are unsigned. Each accepted pair
// gives one culled flag, and a new pair is accepted every cycle while the
// result side keeps up. Stage 1 forms the widened extents, center offsets
// and half-delta magnitudes, stage 2 the offset magnitudes and the
// coordinate-axis test, stage 3 the twelve products of the cross-axis tests,
// stage 4 the 64-bit radius sums and cross magnitudes, stage 5 the compares
// into the output register. A stall on the result side backs up stage by
// stage, so bubbles are squeezed out before the input is held off.
module segment_box_cull_test #(
  parameter int COORD_WIDTH = sbct_pkg::COORD_WIDTH_DEF,
  localparam int CFG_DW     = (COORD_WIDTH - 1 > 32) ? 64 : 32,
  localparam int ADDR_W     = $clog2(sbct_pkg::NUM_REGS * CFG_DW / 8)
) (
  input  logic              clk,
  input  logic              rst_n,
  sbct_in_if.sink           in_ch,
  sbct_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);
  import sbct_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int HW = CW - 1;
  localparam int PW = (2 * CW > ACC_W) ? 2 * CW : ACC_W;
  localparam int AL = $clog2(CFG_DW / 8);
  localparam int AX_I [3] = '{1, 0, 0};
  localparam int AX_J [3] = '{2, 2, 1};

  typedef logic [CW-1:0]    mag_t;
  typedef logic [ACC_W-1:0] acc_t;

  function automatic acc_t mul_acc(input mag_t a, input mag_t b);
    logic [2*CW-1:0] p;
    logic [PW-1:0]   w;
    p = a * b;
    w = PW'(p);
    return w[ACC_W-1:0];
  endfunction

  // configuration registers
  logic [HW-1:0] sweep_x_r, sweep_y_r, sweep_z_r;
  logic          axial_only_r;
  reg_idx_t      reg_sel;
  logic          cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:AL]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_x_r    <= '0;
      sweep_y_r    <= '0;
      sweep_z_r    <= '0;
      axial_only_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_SWEEP_X:    sweep_x_r    <= pwdata[HW-1:0];
        REG_SWEEP_Y:    sweep_y_r    <= pwdata[HW-1:0];
        REG_SWEEP_Z:    sweep_z_r    <= pwdata[HW-1:0];
        REG_AXIAL_ONLY: axial_only_r <= pwdata[0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SWEEP_X:    prdata = CFG_DW'(sweep_x_r);
      REG_SWEEP_Y:    prdata = CFG_DW'(sweep_y_r);
      REG_SWEEP_Z:    prdata = CFG_DW'(sweep_z_r);
      REG_AXIAL_ONLY: prdata = CFG_DW'(axial_only_r);
      default:        prdata = '0;
    endcase
  end

  // stage valids and advance enables
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic en1, en2, en3, en4, en5;

  assign en5         = !out_valid_r || out_ch.ready;
  assign en4         = !v4_r || en5;
  assign en3         = !v3_r || en4;
  assign en2         = !v2_r || en3;
  assign en1         = !v1_r || en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) out_valid_r <= v4_r;
    end
  end

  // stage 1: extents, offsets, half-delta magnitudes
  logic signed [CW-1:0] mid_a [3];
  logic signed [CW-1:0] hd_a  [3];
  logic signed [CW-1:0] ctr_a [3];
  logic [HW-1:0]        bh_a  [3];
  logic [HW-1:0]        sw_a  [3];
  mag_t                 ha1_nxt [3];
  logic                 hn1_nxt [3];
  logic [CW:0]          d1_nxt  [3];
  mag_t                 m1_nxt  [3];
  mag_t                 ha1_r [3];
  logic                 hn1_r [3];
  logic [CW:0]          d1_r  [3];
  mag_t                 m1_r  [3];

  always_comb begin
    mid_a = '{in_ch.seg_mid_x, in_ch.seg_mid_y, in_ch.seg_mid_z};
    hd_a  = '{in_ch.seg_half_x, in_ch.seg_half_y, in_ch.seg_half_z};
    ctr_a = '{in_ch.box_center_x, in_ch.box_center_y, in_ch.box_center_z};
    bh_a  = '{in_ch.box_half_x, in_ch.box_half_y, in_ch.box_half_z};
    sw_a  = '{sweep_x_r, sweep_y_r, sweep_z_r};
    for (int k = 0; k < 3; k++) begin
      hn1_nxt[k] = hd_a[k][CW-1];
      ha1_nxt[k] = hn1_nxt[k] ? mag_t'(-hd_a[k]) : mag_t'(hd_a[k]);
      d1_nxt[k]  = {mid_a[k][CW-1], mid_a[k]} - {ctr_a[k][CW-1], ctr_a[k]};
      m1_nxt[k]  = mag_t'(sw_a[k]) + mag_t'(bh_a[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_ch.valid) begin
      ha1_r <= ha1_nxt;
      hn1_r <= hn1_nxt;
      d1_r  <= d1_nxt;
      m1_r  <= m1_nxt;
    end
  end

  // stage 2: offset magnitudes and coordinate-axis test
  mag_t ha2_r [3];
  logic hn2_r [3];
  mag_t md2_r [3];
  logic dn2_r [3];
  mag_t m2_r  [3];
  logic ax2_r;
  mag_t md2_nxt [3];
  logic dn2_nxt [3];
  logic ax2_nxt;

  always_comb begin
    ax2_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      dn2_nxt[k] = d1_r[k][CW];
      md2_nxt[k] = dn2_nxt[k] ? mag_t'(-d1_r[k]) : d1_r[k][CW-1:0];
      if ((CW+1)'(ha1_r[k]) + (CW+1)'(m1_r[k]) < (CW+1)'(md2_nxt[k])) ax2_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      ha2_r <= ha1_r;
      hn2_r <= hn1_r;
      md2_r <= md2_nxt;
      dn2_r <= dn2_nxt;
      m2_r  <= m1_r;
      ax2_r <= ax2_nxt;
    end
  end

  // stage 3: products of the cross-axis tests
  acc_t rp3_nxt [3], rq3_nxt [3], cp3_nxt [3], cq3_nxt [3];
  logic sd3_nxt [3];
  acc_t rp3_r [3], rq3_r [3], cp3_r [3], cq3_r [3];
  logic sd3_r [3];
  logic ax3_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rp3_nxt[k] = mul_acc(ha2_r[AX_I[k]], m2_r[AX_J[k]]);
      rq3_nxt[k] = mul_acc(m2_r[AX_I[k]], ha2_r[AX_J[k]]);
      cp3_nxt[k] = mul_acc(ha2_r[AX_I[k]], md2_r[AX_J[k]]);
      cq3_nxt[k] = mul_acc(ha2_r[AX_J[k]], md2_r[AX_I[k]]);
      sd3_nxt[k] = (hn2_r[AX_I[k]] ^ dn2_r[AX_J[k]]) != (hn2_r[AX_J[k]] ^ dn2_r[AX_I[k]]);
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      rp3_r <= rp3_nxt;
      rq3_r <= rq3_nxt;
      cp3_r <= cp3_nxt;
      cq3_r <= cq3_nxt;
      sd3_r <= sd3_nxt;
      ax3_r <= ax2_r;
    end
  end

  // stage 4: radius sums and cross magnitudes, modulo 2^64
  acc_t rad4_nxt [3], crs4_nxt [3];
  acc_t rad4_r [3], crs4_r [3];
  logic ax4_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rad4_nxt[k] = rp3_r[k] + rq3_r[k];
      if (sd3_r[k])                 crs4_nxt[k] = cp3_r[k] + cq3_r[k];
      else if (cp3_r[k] >= cq3_r[k]) crs4_nxt[k] = cp3_r[k] - cq3_r[k];
      else                          crs4_nxt[k] = cq3_r[k] - cp3_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      rad4_r <= rad4_nxt;
      crs4_r <= crs4_nxt;
      ax4_r  <= ax3_r;
    end
  end

  // stage 5: compares into the output register
  logic culled_r, culled_nxt;
  logic [2:0] cross_hit;

  always_comb begin
    for (int k = 0; k < 3; k++) cross_hit[k] = rad4_r[k] < crs4_r[k];
    culled_nxt = ax4_r | (!axial_only_r & (|cross_hit));
  end

  always_ff @(posedge clk) begin
    if (en5 && v4_r) culled_r <= culled_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.culled = culled_r;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v1_r)
    else $error("accepted transaction did not enter stage 1");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !en5 |=> v4_r && $stable(ax4_r) && $stable(rad4_r[0]))
    else $error("stage 4 changed while stalled");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(v4_r))
    else $error("result appeared without a stage 4 transaction");

endmodule

// ===== test/sbct_cull_checker.sv =====
`timescale 1ns / 1ps
// cull checker: watches the config port and both channels, predicts and compares culled flags
module sbct_cull_checker (
  input  logic        clk,
  input  logic        rst_n,
  sbct_in_if          in_mon,
  sbct_out_if         out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          outstanding
);
  import sbct_pkg::*;

  typedef struct {
    logic signed [31:0] mid [3];
    logic signed [31:0] dir [3];
    logic signed [31:0] ctr [3];
    logic [30:0]        ext [3];
  } seg_box_t;

  logic [30:0] sweep [3];
  logic        axial;
  logic        cull_q [$];

  function automatic logic [63:0] magn(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // |a*b - c*e| formed from sign and magnitude
  function automatic logic [63:0] cross_mag(input longint a, input longint b,
                                            input longint c, input longint e);
    logic        neg_p, neg_q;
    logic [63:0] mp, mq;
    neg_p = (a < 0) != (b < 0);
    neg_q = (c < 0) != (e < 0);
    mp = magn(a) * magn(b);
    mq = magn(c) * magn(e);
    if (neg_p != neg_q) return mp + mq;
    return (mp >= mq) ? mp - mq : mq - mp;
  endfunction

  function automatic logic predict_cull(input seg_box_t p, input logic [30:0] sw [3],
                                        input logic axial_only);
    longint      h [3];
    longint      d [3];
    logic [63:0] ha [3];
    logic [63:0] rad [3];
    logic        hit;
    hit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      h[i]   = p.dir[i];
      d[i]   = longint'(p.mid[i]) - longint'(p.ctr[i]);
      ha[i]  = magn(h[i]);
      rad[i] = 64'(sw[i]) + 64'(p.ext[i]);
      if (ha[i] + rad[i] < magn(d[i])) hit = 1'b1;
    end
    if (!hit && !axial_only) begin
      if (ha[1] * rad[2] + rad[1] * ha[2] < cross_mag(h[1], d[2], h[2], d[1])) begin
        hit = 1'b1;
      end else if (ha[0] * rad[2] + rad[0] * ha[2] < cross_mag(h[2], d[0], h[0], d[2])) begin
        hit = 1'b1;
      end else if (ha[1] * rad[0] + ha[0] * rad[1] < cross_mag(h[0], d[1], h[1], d[0])) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  always @(posedge clk) begin
    seg_box_t pr;
    logic     want;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) sweep[i] <= '0;
      axial <= 1'b0;
      cull_q.delete();
      errors <= 0;
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_SWEEP_X:    sweep[0] <= pwdata[30:0];
          REG_SWEEP_Y:    sweep[1] <= pwdata[30:0];
          REG_SWEEP_Z:    sweep[2] <= pwdata[30:0];
          REG_AXIAL_ONLY: axial <= pwdata[0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (cull_q.size() == 0) begin
          if (errors < 10) $display("%0t: culled result %0b with no transaction pending",
                                    $realtime, out_mon.culled);
          errors <= errors + 1;
        end else begin
          want = cull_q.pop_front();
          if (out_mon.culled !== want) begin
            if (errors < 10) $display("%0t: culled expected %0b actual %0b",
                                      $realtime, want, out_mon.culled);
            errors <= errors + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pr.mid[0] = in_mon.seg_mid_x;
        pr.mid[1] = in_mon.seg_mid_y;
        pr.mid[2] = in_mon.seg_mid_z;
        pr.dir[0] = in_mon.seg_half_x;
        pr.dir[1] = in_mon.seg_half_y;
        pr.dir[2] = in_mon.seg_half_z;
        pr.ctr[0] = in_mon.box_center_x;
        pr.ctr[1] = in_mon.box_center_y;
        pr.ctr[2] = in_mon.box_center_z;
        pr.ext[0] = in_mon.box_half_x;
        pr.ext[1] = in_mon.box_half_y;
        pr.ext[2] = in_mon.box_half_z;
        cull_q.push_back(predict_cull(pr, sweep, axial));
      end
      outstanding <= cull_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// testbench top: clock, reset, config writes, segment and box stimulus, and the verdict
module tb_top;
  import sbct_pkg::*;

  typedef struct {
    logic signed [31:0] mid [3];
    logic signed [31:0] dir [3];
    logic signed [31:0] ctr [3];
    logic [30:0]        ext [3];
  } pair_t;

  localparam logic signed [31:0] CMAX = 32'sh7fffffff;
  localparam logic signed [31:0] CMIN = 32'sh80000000;
  localparam logic [30:0]        EMAX = 31'h7fffffff;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        idle_on;
  int          errors, outstanding;

  sbct_in_if  in_ch ();
  sbct_out_if out_ch ();

  segment_box_cull_test dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sbct_cull_checker cull_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #1 clk = ~clk;

  function automatic logic signed [31:0] rand_coord(input int bits);
    return $signed($urandom) >>> (31 - bits);
  endfunction

  function automatic logic [30:0] rand_ext(input int bits);
    return 31'($urandom >> (32 - bits));
  endfunction

  function automatic pair_t fill_pair(input logic signed [31:0] m, input logic signed [31:0] d,
                                      input logic signed [31:0] c, input logic [30:0] e);
    pair_t p;
    for (int i = 0; i < 3; i++) begin
      p.mid[i] = m;
      p.dir[i] = d;
      p.ctr[i] = c;
      p.ext[i] = e;
    end
    return p;
  endfunction

  // mostly nearby boxes at a random scale, some fully random noise
  function automatic pair_t rand_pair();
    pair_t p;
    int    k;
    if ($urandom_range(0, 6) == 0) begin
      for (int i = 0; i < 3; i++) begin
        p.mid[i] = $urandom;
        p.dir[i] = $urandom;
        p.ctr[i] = $urandom;
        p.ext[i] = 31'($urandom);
      end
    end else begin
      k = $urandom_range(2, 30);
      for (int i = 0; i < 3; i++) begin
        p.mid[i] = rand_coord(k);
        p.ctr[i] = p.mid[i] + rand_coord(k);
        p.dir[i] = rand_coord(k);
        p.ext[i] = rand_ext(k);
      end
    end
    return p;
  endfunction

  task automatic send_pair(input pair_t p);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.seg_mid_x    <= p.mid[0];
    in_ch.seg_mid_y    <= p.mid[1];
    in_ch.seg_mid_z    <= p.mid[2];
    in_ch.seg_half_x   <= p.dir[0];
    in_ch.seg_half_y   <= p.dir[1];
    in_ch.seg_half_z   <= p.dir[2];
    in_ch.box_center_x <= p.ctr[0];
    in_ch.box_center_y <= p.ctr[1];
    in_ch.box_center_z <= p.ctr[2];
    in_ch.box_half_x   <= p.ext[0];
    in_ch.box_half_y   <= p.ext[1];
    in_ch.box_half_z   <= p.ext[2];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // unused upper bits get random values, the block must drop them
  task automatic set_config(input logic [30:0] sw_x, input logic [30:0] sw_y,
                            input logic [30:0] sw_z, input logic ax);
    write_reg(REG_SWEEP_X, {1'($urandom), sw_x});
    write_reg(REG_SWEEP_Y, {1'($urandom), sw_y});
    write_reg(REG_SWEEP_Z, {1'($urandom), sw_z});
    write_reg(REG_AXIAL_ONLY, {31'($urandom), ax});
  endtask

  initial begin
    int burst;
    out_ch.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 10);
        out_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    pair_t p;
    int    b, c;
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    idle_on = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.seg_mid_x    = '0;
    in_ch.seg_mid_y    = '0;
    in_ch.seg_mid_z    = '0;
    in_ch.seg_half_x   = '0;
    in_ch.seg_half_y   = '0;
    in_ch.seg_half_z   = '0;
    in_ch.box_center_x = '0;
    in_ch.box_center_y = '0;
    in_ch.box_center_z = '0;
    in_ch.box_half_x   = '0;
    in_ch.box_half_y   = '0;
    in_ch.box_half_z   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed transactions at reset config
    send_pair(fill_pair(0, 0, 0, 0));
    for (int a = 0; a < 3; a++) begin
      // tie on one axis, then one lsb past it
      p = fill_pair(0, 0, 0, 0);
      p.mid[a] = 32'sd2560;
      p.ext[a] = 31'd2560;
      send_pair(p);
      p.mid[a] = 32'sd2561;
      send_pair(p);
    end
    send_pair(fill_pair(CMAX, 0, CMIN, 0));
    send_pair(fill_pair(CMIN, 0, CMAX, 0));
    send_pair(fill_pair(CMAX, CMAX, CMAX, EMAX));
    send_pair(fill_pair(CMIN, CMIN, CMIN, EMAX));
    send_pair(fill_pair(0, CMIN, 0, 0));
    send_pair(fill_pair(CMAX, CMIN, CMIN, EMAX));
    // zero segment delta
    send_pair(fill_pair(32'sd100, 0, 0, 31'd99));
    send_pair(fill_pair(32'sd100, 0, 0, 31'd100));
    // diagonal segments near a box edge: only a cross axis separates
    for (int a = 0; a < 3; a++) begin
      b = (a + 1) % 3;
      p = fill_pair(0, 0, 0, 31'd256);
      p.mid[a] = 32'sd512;
      p.mid[b] = 32'sd512;
      p.dir[a] = 32'sd2560;
      p.dir[b] = -32'sd2560;
      send_pair(p);
      p.dir[b] = 32'sd2560;
      send_pair(p);
    end

    for (int ph = 0; ph < 8; ph++) begin
      in_ch.valid <= 1'b0;
      wait_drained();
      case (ph)
        0: set_config(EMAX, EMAX, EMAX, 1'b0);
        1: set_config('0, '0, '0, 1'b1);
        2: set_config(EMAX, EMAX, EMAX, 1'b1);
        3: set_config('0, '0, '0, 1'b0);
        default: begin
          c = $urandom_range(0, 20);
          set_config(rand_ext(c), rand_ext(c), rand_ext($urandom_range(0, 20)),
                     1'($urandom_range(0, 1)));
        end
      endcase
      idle_on <= (ph != 7) && (ph % 3 != 2);
      repeat (88) send_pair(rand_pair());
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
